[rtl/rdcs_pkg.sv]
`default_nettype none

package rdcs_pkg;

    localparam int unsigned TIME_BITS = 32;
    localparam int unsigned CFG_INDEX_BITS = 3;

    localparam logic [TIME_BITS-1:0] POLL_GAP_MS = TIME_BITS'(1000);

    typedef logic [TIME_BITS-1:0] t_time;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_WAITREG = 2'd1,
        PH_WINDOW  = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_FORCE = 3'd1,
        OP_WAKE  = 3'd2,
        OP_SLEEP = 3'd3,
        OP_IDLE  = 3'd4
    } t_op;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ENABLE   = 3'd0,
        CFG_COOLDOWN = 3'd1,
        CFG_INTERVAL = 3'd2,
        CFG_REG_TO   = 3'd3,
        CFG_WINDOW   = 3'd4
    } t_cfg_index;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_ON   = 2'd1;
    localparam logic [1:0] CMD_OFF  = 2'd2;

    localparam logic [1:0] OPEN_NONE     = 2'd0;
    localparam logic [1:0] OPEN_URGENT   = 2'd1;
    localparam logic [1:0] OPEN_PERIODIC = 2'd2;
    localparam logic [1:0] OPEN_BACKLOG  = 2'd3;

    localparam logic [1:0] CLOSE_NONE    = 2'd0;
    localparam logic [1:0] CLOSE_REG_TO  = 2'd1;
    localparam logic [1:0] CLOSE_ELAPSED = 2'd2;
    localparam logic [1:0] CLOSE_SLEEP   = 2'd3;

    localparam logic signed [3:0] REG_HOME    = 4'sd1;
    localparam logic signed [3:0] REG_ROAMING = 4'sd5;

    localparam logic [31:0] RST_COOLDOWN = 32'd30000;
    localparam logic [31:0] RST_INTERVAL = 32'd600000;
    localparam logic [31:0] RST_REG_TO   = 32'd30000;
    localparam logic [31:0] RST_WINDOW   = 32'd60000;

    typedef struct packed {
        logic        enable;
        logic [31:0] cooldown_ms;
        logic [31:0] wake_interval_ms;
        logic [31:0] reg_timeout_ms;
        logic [31:0] window_ms;
    } t_cfg;

    typedef struct packed {
        t_phase phase;
        logic   awake;
        logic   urgent;
        t_time  phase_since;
        t_time  last_close;
        t_time  last_periodic;
        t_time  last_poll;
    } t_state;

    typedef struct packed {
        logic [2:0]        op;
        logic [31:0]       now_ms;
        logic              backlog;
        logic signed [3:0] reg_status;
    } t_item;

    typedef struct packed {
        logic [1:0] radio_cmd;
        logic       reg_poll;
        logic [1:0] phase;
        logic       radio_up;
        logic [1:0] open_reason;
        logic [1:0] close_reason;
    } t_result;

endpackage

`default_nettype wire

[rtl/rdcs_if.sv]
`default_nettype none

interface rdcs_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        op;
    logic [31:0]       now_ms;
    logic              backlog;
    logic signed [3:0] reg_status;

    modport source (output valid, output op, output now_ms, output backlog,
                    output reg_status, input ready);
    modport sink (input valid, input op, input now_ms, input backlog,
                  input reg_status, output ready);
endinterface

interface rdcs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] radio_cmd;
    logic       reg_poll;
    logic [1:0] phase;
    logic       radio_up;
    logic [1:0] open_reason;
    logic [1:0] close_reason;

    modport source (output valid, output radio_cmd, output reg_poll, output phase,
                    output radio_up, output open_reason, output close_reason,
                    input ready);
    modport sink (input valid, input radio_cmd, input reg_poll, input phase,
                  input radio_up, input open_reason, input close_reason,
                  output ready);
endinterface

interface rdcs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/rdcs_step.sv]
`default_nettype none

module rdcs_step (
    input  wire rdcs_pkg::t_cfg   i_cfg,
    input  wire rdcs_pkg::t_state i_state,
    input  wire rdcs_pkg::t_item  i_item,
    output rdcs_pkg::t_state  o_state,
    output rdcs_pkg::t_result o_result
);

    rdcs_pkg::t_time now;
    logic            cool;
    logic            due;
    logic            poll_due;
    logic            reg_ok;
    logic            reg_to;
    logic            win_done;

    assign now      = rdcs_pkg::TIME_BITS'(i_item.now_ms);
    assign cool     = rdcs_pkg::t_time'(now - i_state.last_close) >= i_cfg.cooldown_ms;
    assign due      = rdcs_pkg::t_time'(now - i_state.last_periodic)
                      >= i_cfg.wake_interval_ms;
    assign poll_due = rdcs_pkg::t_time'(now - i_state.last_poll) >= rdcs_pkg::POLL_GAP_MS;
    assign reg_ok   = (i_item.reg_status == rdcs_pkg::REG_HOME)
                   || (i_item.reg_status == rdcs_pkg::REG_ROAMING);
    assign reg_to   = rdcs_pkg::t_time'(now - i_state.phase_since) >= i_cfg.reg_timeout_ms;
    assign win_done = rdcs_pkg::t_time'(now - i_state.phase_since) >= i_cfg.window_ms;

    always_comb begin
        o_state                 = i_state;
        o_result.radio_cmd      = rdcs_pkg::CMD_NONE;
        o_result.reg_poll       = 1'b0;
        o_result.open_reason    = rdcs_pkg::OPEN_NONE;
        o_result.close_reason   = rdcs_pkg::CLOSE_NONE;

        case (i_item.op)
            rdcs_pkg::OP_FORCE: begin
                o_state.urgent = 1'b1;
            end
            rdcs_pkg::OP_WAKE: begin
                if (i_cfg.enable && !i_state.awake) begin
                    o_state.awake  = 1'b1;
                    o_state.urgent = 1'b0;
                end
            end
            rdcs_pkg::OP_SLEEP: begin
                if (i_cfg.enable) begin
                    o_state.awake         = 1'b0;
                    o_state.last_close    = now;
                    o_result.close_reason = rdcs_pkg::CLOSE_SLEEP;
                end
            end
            rdcs_pkg::OP_IDLE: begin
                if (i_cfg.enable) begin
                    o_result.radio_cmd    = rdcs_pkg::CMD_OFF;
                    o_state.awake         = 1'b0;
                    o_state.phase         = rdcs_pkg::PH_IDLE;
                    o_state.last_close    = now;
                    o_result.close_reason = rdcs_pkg::CLOSE_SLEEP;
                end
            end
            rdcs_pkg::OP_TICK: begin
                if (i_cfg.enable) begin
                    case (i_state.phase)
                        rdcs_pkg::PH_IDLE: begin
                            if (!i_state.awake && (i_state.urgent || cool)
                                && (i_state.urgent || due || i_item.backlog)) begin
                                o_result.radio_cmd = rdcs_pkg::CMD_ON;
                                if (i_state.urgent) begin
                                    o_result.open_reason = rdcs_pkg::OPEN_URGENT;
                                end else if (due) begin
                                    o_result.open_reason = rdcs_pkg::OPEN_PERIODIC;
                                end else begin
                                    o_result.open_reason = rdcs_pkg::OPEN_BACKLOG;
                                end
                                o_state.awake = 1'b1;
                                if (due) begin
                                    o_state.last_periodic = now;
                                end
                                o_state.phase       = rdcs_pkg::PH_WAITREG;
                                o_state.phase_since = now;
                            end
                        end
                        rdcs_pkg::PH_WAITREG: begin
                            if (poll_due) begin
                                o_state.last_poll = now;
                                o_result.reg_poll = 1'b1;
                            end
                            if (poll_due && reg_ok) begin
                                o_state.urgent      = 1'b0;
                                o_state.phase       = rdcs_pkg::PH_WINDOW;
                                o_state.phase_since = now;
                            end else if (reg_to) begin
                                o_state.urgent        = 1'b0;
                                o_result.radio_cmd    = rdcs_pkg::CMD_OFF;
                                o_state.awake         = 1'b0;
                                o_state.phase         = rdcs_pkg::PH_IDLE;
                                o_state.last_close    = now;
                                o_result.close_reason = rdcs_pkg::CLOSE_REG_TO;
                            end
                        end
                        rdcs_pkg::PH_WINDOW: begin
                            if (win_done) begin
                                o_result.radio_cmd    = rdcs_pkg::CMD_OFF;
                                o_state.awake         = 1'b0;
                                o_state.phase         = rdcs_pkg::PH_IDLE;
                                o_state.last_close    = now;
                                o_result.close_reason = rdcs_pkg::CLOSE_ELAPSED;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        o_result.phase    = o_state.phase;
        o_result.radio_up = o_state.awake;
    end

endmodule

`default_nettype wire

[rtl/radio_duty_cycle_scheduler.sv]
// Channel   Dir  Handshake        Payload
// i_req     in   valid / ready    op, now_ms, backlog, reg_status
// o_rsp     out  valid / ready    radio_cmd, reg_poll, phase, radio_up, open_reason,
//                                 close_reason
// i_cfg     in   valid / ready    index, data (register write, always ready)
//
// A request is held in the input register at acceptance, and its result passes through the
// event logic into the output register once the output register is free to advance.
// A new request is accepted every cycle while the result side keeps up.
// A stalled result holds in the output register; the input register still takes one more.
// Synchronous active-low reset restores the power-on registers and schedule state.

`default_nettype none

module radio_duty_cycle_scheduler (
    input  wire              i_clk,
    input  wire              i_rst_n,
    rdcs_in_if.sink          i_req,
    rdcs_out_if.source       o_rsp,
    rdcs_cfg_if.sink         i_cfg
);

    rdcs_pkg::t_cfg    r_cfg;
    rdcs_pkg::t_state  r_state;
    rdcs_pkg::t_state  n_state;
    rdcs_pkg::t_item   r_in;
    logic              r_in_valid;
    rdcs_pkg::t_result r_out;
    rdcs_pkg::t_result n_out;
    logic              r_out_valid;
    logic              advance;
    logic              in_accept;

    assign advance     = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_in_valid || advance;
    assign in_accept   = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    rdcs_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable           <= 1'b1;
            r_cfg.cooldown_ms      <= rdcs_pkg::RST_COOLDOWN;
            r_cfg.wake_interval_ms <= rdcs_pkg::RST_INTERVAL;
            r_cfg.reg_timeout_ms   <= rdcs_pkg::RST_REG_TO;
            r_cfg.window_ms        <= rdcs_pkg::RST_WINDOW;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                rdcs_pkg::CFG_ENABLE:   r_cfg.enable           <= i_cfg.data[0];
                rdcs_pkg::CFG_COOLDOWN: r_cfg.cooldown_ms      <= i_cfg.data;
                rdcs_pkg::CFG_INTERVAL: r_cfg.wake_interval_ms <= i_cfg.data;
                rdcs_pkg::CFG_REG_TO:   r_cfg.reg_timeout_ms   <= i_cfg.data;
                rdcs_pkg::CFG_WINDOW:   r_cfg.window_ms        <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= rdcs_pkg::PH_IDLE;
            r_state.awake         <= 1'b1;
            r_state.urgent        <= 1'b0;
            r_state.phase_since   <= '0;
            r_state.last_close    <= '0;
            r_state.last_periodic <= '0;
            r_state.last_poll     <= '0;
            r_in_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.op         <= i_req.op;
            r_in.now_ms     <= i_req.now_ms;
            r_in.backlog    <= i_req.backlog;
            r_in.reg_status <= i_req.reg_status;
        end
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.radio_cmd    = r_out.radio_cmd;
    assign o_rsp.reg_poll     = r_out.reg_poll;
    assign o_rsp.phase        = r_out.phase;
    assign o_rsp.radio_up     = r_out.radio_up;
    assign o_rsp.open_reason  = r_out.open_reason;
    assign o_rsp.close_reason = r_out.close_reason;

endmodule

`default_nettype wire

[dv/radio_duty_cycle_scheduler_tb.sv]
`timescale 1ns / 100ps

module radio_duty_cycle_scheduler_tb;
    import rdcs_pkg::*;

    localparam int MAX_GAP         = 12;
    localparam int DRAIN_CYCLES    = 4;
    localparam int RSP_HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES   = 11;
    localparam int PHASE_REQUESTS  = 160;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int MAX_REPORTS     = 40;

    logic i_clk;
    logic i_rst_n;

    rdcs_in_if  req_if ();
    rdcs_out_if rsp_if ();
    rdcs_cfg_if cfg_if ();

    radio_duty_cycle_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    t_cfg    sched_cfg;
    t_state  sched_st;
    t_result predicted_results[$];
    t_time   sim_now;

    bit burst_mode;
    bit rsp_hold_req;
    int mismatch_count;
    int requests_sent;
    int results_seen;
    int cycle_count;
    int polls_seen;
    int opens_seen[4];
    int closes_seen[4];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, predicted_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_result schedule_outcome(t_item it);
        t_result r;
        t_time   now;
        logic    cool;
        logic    due;
        logic    urg;
        logic    registered;
        r = '0;
        now = it.now_ms;
        if (it.op == OP_FORCE) begin
            sched_st.urgent = 1'b1;
        end else if (sched_cfg.enable) begin
            case (it.op)
                OP_WAKE: begin
                    if (!sched_st.awake) begin
                        sched_st.awake = 1'b1;
                        sched_st.urgent = 1'b0;
                    end
                end
                OP_SLEEP: begin
                    sched_st.awake = 1'b0;
                    sched_st.last_close = now;
                    r.close_reason = CLOSE_SLEEP;
                end
                OP_IDLE: begin
                    r.radio_cmd = CMD_OFF;
                    sched_st.awake = 1'b0;
                    sched_st.phase = PH_IDLE;
                    sched_st.last_close = now;
                    r.close_reason = CLOSE_SLEEP;
                end
                OP_TICK: begin
                    case (sched_st.phase)
                        PH_IDLE: begin
                            cool = t_time'(now - sched_st.last_close) >= sched_cfg.cooldown_ms;
                            due = t_time'(now - sched_st.last_periodic)
                                  >= sched_cfg.wake_interval_ms;
                            urg = sched_st.urgent;
                            if (!sched_st.awake && (urg || cool) && (urg || due || it.backlog)) begin
                                r.radio_cmd = CMD_ON;
                                r.open_reason = urg ? OPEN_URGENT :
                                                (due ? OPEN_PERIODIC : OPEN_BACKLOG);
                                sched_st.awake = 1'b1;
                                if (due) begin
                                    sched_st.last_periodic = now;
                                end
                                sched_st.phase = PH_WAITREG;
                                sched_st.phase_since = now;
                            end
                        end
                        PH_WAITREG: begin
                            registered = 1'b0;
                            if (t_time'(now - sched_st.last_poll) >= POLL_GAP_MS) begin
                                sched_st.last_poll = now;
                                r.reg_poll = 1'b1;
                                if (it.reg_status == REG_HOME || it.reg_status == REG_ROAMING) begin
                                    registered = 1'b1;
                                    sched_st.urgent = 1'b0;
                                    sched_st.phase = PH_WINDOW;
                                    sched_st.phase_since = now;
                                end
                            end
                            if (!registered && t_time'(now - sched_st.phase_since)
                                    >= sched_cfg.reg_timeout_ms) begin
                                sched_st.urgent = 1'b0;
                                r.radio_cmd = CMD_OFF;
                                sched_st.awake = 1'b0;
                                sched_st.phase = PH_IDLE;
                                sched_st.last_close = now;
                                r.close_reason = CLOSE_REG_TO;
                            end
                        end
                        PH_WINDOW: begin
                            if (t_time'(now - sched_st.phase_since) >= sched_cfg.window_ms) begin
                                r.radio_cmd = CMD_OFF;
                                sched_st.awake = 1'b0;
                                sched_st.phase = PH_IDLE;
                                sched_st.last_close = now;
                                r.close_reason = CLOSE_ELAPSED;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        r.phase = sched_st.phase;
        r.radio_up = sched_st.awake;
        return r;
    endfunction

    task automatic flag_mismatch(string field, int got, int want);
        if (mismatch_count < MAX_REPORTS) begin
            $display("Mismatch on result %0d, %s: got %0d, expected %0d.",
                     results_seen, field, got, want);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (predicted_results.size() == 0) begin
                flag_mismatch("unexpected result", 1, 0);
            end else begin
                want = predicted_results.pop_front();
                if (rsp_if.radio_cmd !== want.radio_cmd)
                    flag_mismatch("radio_cmd", rsp_if.radio_cmd, want.radio_cmd);
                if (rsp_if.reg_poll !== want.reg_poll)
                    flag_mismatch("reg_poll", rsp_if.reg_poll, want.reg_poll);
                if (rsp_if.phase !== want.phase)
                    flag_mismatch("phase", rsp_if.phase, want.phase);
                if (rsp_if.radio_up !== want.radio_up)
                    flag_mismatch("radio_up", rsp_if.radio_up, want.radio_up);
                if (rsp_if.open_reason !== want.open_reason)
                    flag_mismatch("open_reason", rsp_if.open_reason, want.open_reason);
                if (rsp_if.close_reason !== want.close_reason)
                    flag_mismatch("close_reason", rsp_if.close_reason, want.close_reason);
                opens_seen[want.open_reason]++;
                closes_seen[want.close_reason]++;
                polls_seen += want.reg_poll;
            end
            results_seen++;
        end
    end

    // A long hold is taken once per request from the stimulus and counted here.
    initial begin
        int stall;
        rsp_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (rsp_hold_req) begin
                rsp_hold_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(posedge i_clk);
            end
            stall = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_if.valid && !rsp_hold_req) @(posedge i_clk);
        end
    end

    task automatic send_request(t_item it);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.op         <= it.op;
        req_if.now_ms     <= it.now_ms;
        req_if.backlog    <= it.backlog;
        req_if.reg_status <= it.reg_status;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted_results.push_back(schedule_outcome(it));
        requests_sent++;
    endtask

    task automatic send_event(logic [2:0] op, t_time now, logic backlog,
                              logic signed [3:0] status);
        t_item it;
        it.op = op;
        it.now_ms = now;
        it.backlog = backlog;
        it.reg_status = status;
        send_request(it);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(logic en, t_time cool, t_time interval, t_time reg_to,
                             t_time win);
        t_cfg_index idx[5];
        logic [31:0] val[5];
        idx = '{CFG_ENABLE, CFG_COOLDOWN, CFG_INTERVAL, CFG_REG_TO, CFG_WINDOW};
        val = '{{31'd0, en}, cool, interval, reg_to, win};
        wait_drained();
        for (int k = 0; k < 5; k++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[k];
            cfg_if.data  <= val[k];
            @(posedge i_clk);
            while (!cfg_if.ready) @(posedge i_clk);
        end
        cfg_if.valid <= 1'b0;
        sched_cfg.enable = en;
        sched_cfg.cooldown_ms = cool;
        sched_cfg.wake_interval_ms = interval;
        sched_cfg.reg_timeout_ms = reg_to;
        sched_cfg.window_ms = win;
    endtask

    function automatic t_time pick_span();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        if (sel == 2) return t_time'($urandom);
        return t_time'($urandom_range(1, 6000));
    endfunction

    function automatic t_item random_event();
        t_item it;
        int pick;
        int advance;
        advance = $urandom_range(0, 99);
        if (advance < 70) sim_now += t_time'($urandom_range(0, 1200));
        else if (advance < 90) sim_now += t_time'($urandom_range(0, 8000));
        else if (advance < 97) sim_now += t_time'($urandom);
        it.now_ms = sim_now;
        it.backlog = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1) != 0)
            it.reg_status = ($urandom_range(0, 1) != 0) ? REG_HOME : REG_ROAMING;
        else
            it.reg_status = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 68) it.op = OP_TICK;
        else if (pick < 76) it.op = OP_FORCE;
        else if (pick < 82) it.op = OP_WAKE;
        else if (pick < 88) it.op = OP_SLEEP;
        else if (pick < 94) it.op = OP_IDLE;
        else if (pick < 97) it.op = 3'($urandom_range(int'(OP_IDLE) + 1, 7));
        else begin
            it.op = 3'($urandom_range(0, 7));
            it.now_ms = t_time'($urandom);
        end
        return it;
    endfunction

    task automatic test_directed_sequence();
        send_event(OP_TICK, 32'd0, 1'b1, REG_HOME);
        send_event(OP_WAKE, 32'd50, 1'b0, REG_HOME);
        send_event(OP_SLEEP, 32'd100, 1'b0, REG_HOME);
        send_event(OP_TICK, 32'd200, 1'b1, REG_HOME);
        send_event(OP_FORCE, 32'd300, 1'b0, REG_HOME);
        send_event(OP_TICK, 32'd400, 1'b0, REG_HOME);
        send_event(OP_TICK, 32'd500, 1'b0, -4'sd1);
        send_event(OP_TICK, 32'd1000, 1'b0, 4'sd0);
        send_event(OP_TICK, 32'd1500, 1'b0, REG_ROAMING);
        send_event(OP_TICK, 32'd2000, 1'b0, REG_ROAMING);
        send_event(OP_TICK, 32'd61999, 1'b1, REG_HOME);
        send_event(OP_TICK, 32'd62000, 1'b0, REG_HOME);
        send_event(OP_TICK, 32'd92000, 1'b1, REG_HOME);
        send_event(OP_TICK, 32'd122000, 1'b0, -4'sd8);
        send_event(OP_TICK, 32'hFFFF_FFFF, 1'b0, 4'sd7);
        send_event(OP_TICK, 32'd1024, 1'b0, REG_HOME);
        send_event(OP_IDLE, 32'd2000, 1'b0, REG_HOME);
        send_event(OP_FORCE, 32'd2100, 1'b0, REG_HOME);
        send_event(OP_WAKE, 32'd2200, 1'b0, REG_HOME);
        send_event(OP_TICK, 32'd2300, 1'b1, REG_HOME);
        send_event(3'(int'(OP_IDLE) + 1), 32'd7, 1'b1, 4'sd7);
        send_event(3'(int'(OP_IDLE) + 2), 32'hFFFF_FFFF, 1'b0, -4'sd8);
        send_event(3'(int'(OP_IDLE) + 3), 32'h5555_AAAA, 1'b1, REG_ROAMING);
        send_event(OP_SLEEP, 32'hFFFF_FFFF, 1'b1, REG_HOME);
    endtask

    task automatic test_cycling_disabled();
        configure(1'b0, RST_COOLDOWN, RST_INTERVAL, RST_REG_TO, RST_WINDOW);
        send_event(OP_TICK, 32'd5000000, 1'b1, REG_HOME);
        send_event(OP_WAKE, 32'd5000100, 1'b0, REG_HOME);
        send_event(OP_SLEEP, 32'd5000200, 1'b0, REG_HOME);
        send_event(OP_IDLE, 32'd5000300, 1'b0, REG_HOME);
        send_event(OP_FORCE, 32'd5000400, 1'b0, REG_HOME);
        send_event(OP_TICK, 32'd5000500, 1'b1, REG_HOME);
        configure(1'b1, RST_COOLDOWN, RST_INTERVAL, RST_REG_TO, RST_WINDOW);
        send_event(OP_TICK, 32'd5000600, 1'b0, REG_HOME);
    endtask

    task automatic test_backpressure();
        configure(1'b1, 32'd500, 32'd2000, 32'd1500, 32'd3000);
        sim_now = 32'd10000000;
        burst_mode = 1'b1;
        rsp_hold_req = 1'b1;
        for (int n = 0; n < 40; n++) send_request(random_event());
        wait_drained();
        for (int n = 0; n < 20; n++) send_request(random_event());
        burst_mode = 1'b0;
    endtask

    task automatic test_random_schedules();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0)
                configure(1'b1, '0, '0, '0, '0);
            else if (ph == 1)
                configure(1'b1, '1, '1, '1, '1);
            else
                configure(1'($urandom_range(0, 7) != 0), pick_span(), pick_span(),
                          pick_span(), pick_span());
            if ($urandom_range(0, 3) == 0)
                sim_now = 32'hFFFF_FFFF - t_time'($urandom_range(0, 20000));
            burst_mode = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_REQUESTS; n++) send_request(random_event());
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.op = OP_TICK;
        req_if.now_ms = '0;
        req_if.backlog = 1'b0;
        req_if.reg_status = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_ENABLE;
        cfg_if.data = '0;
        sched_cfg = '{enable: 1'b1, cooldown_ms: RST_COOLDOWN,
                      wake_interval_ms: RST_INTERVAL, reg_timeout_ms: RST_REG_TO,
                      window_ms: RST_WINDOW};
        sched_st = '0;
        sched_st.phase = PH_IDLE;
        sched_st.awake = 1'b1;
        sim_now = '0;
        burst_mode = 1'b0;
        rsp_hold_req = 1'b0;
        mismatch_count = 0;
        requests_sent = 0;
        results_seen = 0;
        cycle_count = 0;
        polls_seen = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_sequence();
        test_cycling_disabled();
        test_backpressure();
        test_random_schedules();
        wait_drained();

        $display("Sent %0d requests and checked %0d results over %0d cycles.",
                 requests_sent, results_seen, cycle_count);
        $display("Opens urgent/periodic/backlog %0d/%0d/%0d, closes timeout/elapsed/sleep "
                 , opens_seen[OPEN_URGENT], opens_seen[OPEN_PERIODIC],
                 opens_seen[OPEN_BACKLOG]);
        $display("%0d/%0d/%0d, %0d registration polls.", closes_seen[CLOSE_REG_TO],
                 closes_seen[CLOSE_ELAPSED], closes_seen[CLOSE_SLEEP], polls_seen);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
